// ----- src/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants of the differential drive odometry block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  localparam logic [31:0] ANG_PER_RAD = 32'd683565276;
  localparam logic [31:0] PIHALF_Q30  = 32'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] US_PER_S    = 32'd1000000;

  localparam logic [18:0] WHEEL_BASE_RST  = 19'd9830;
  localparam logic [30:0] SMALL_ANGLE_RST = 31'd23860929;

  typedef enum logic [0:0] {
    REG_WHEEL_BASE  = 1'b0,
    REG_SMALL_ANGLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_ISSUE  = 5'b00010,
    ST_WAIT   = 5'b00100,
    ST_WB     = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    S_ANG_MUL, S_ANG_DIV, S_X, S_X2,
    S_SD0, S_SM1, S_SD1, S_SM2, S_SD2, S_SM3, S_SD3, S_SX,
    S_CD0, S_CM1, S_CD1, S_CM2, S_CD2, S_CM3, S_CD3, S_CM4, S_CD4,
    S_STR_X, S_STR_Y, S_ARC_R, S_ARC_RQ, S_ARC_X, S_ARC_Y,
    S_SPD_MUL, S_SPD_DIV, S_RT_DEN, S_RT_MUL, S_RT_DIV
  } step_t;

endpackage

`default_nettype wire

// ----- src/diff_drive_odometry_core.sv -----
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Wheel odometry for a differential drive: pose, speed and turn rate.
//
// Input channel (in_valid/in_stall) carries one tick of left and right wheel
// travel and the tick length; each transfer yields exactly one result on the
// output channel (out_valid/out_stall): pose, heading, speed and turn rate.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// by the user only while the block is idle; the block does not enforce it.
// One tick is worked through a sequencer driving a shared 4-bit-digit
// multiplier and a shared radix-2 divider. The result is registered once
// the last step of the straight or the arc path is done; one tick is in
// work at a time.
// The result sits in an output register, so a new tick is taken while it
// waits; out_stall only holds that register, and a finished tick that
// finds it still occupied waits in place.
// Reset (rst, synchronous) clears the pose, loads the register defaults
// and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    left_dist,
  input  logic signed [31:0]    right_dist,
  input  logic        [19:0]    tick_time_us,
  input  logic                  cfg_we,
  input  ddo_pkg::cfg_reg_t     cfg_index,
  input  logic        [30:0]    cfg_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [47:0]    pos_x,
  output logic signed [47:0]    pos_y,
  output logic signed [31:0]    heading,
  output logic signed [31:0]    speed,
  output logic signed [31:0]    turn_rate
);
  import ddo_pkg::*;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? (32'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic [71:0] q, input logic neg);
    logic big;
    big = |q[71:31];
    if (neg) begin
      sat32 = big ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      sat32 = big ? 32'h7FFF_FFFF : q[31:0];
    end
  endfunction

  state_t       state;
  step_t        pc;
  logic         pass;
  logic         straight;

  logic [18:0]  wheel_base;
  logic [30:0]  small_angle_limit;
  logic [47:0]  acc_x;
  logic [47:0]  acc_y;
  logic [31:0]  acc_heading;

  logic [32:0]  usum;
  logic [32:0]  udiff;
  logic         sum_neg;
  logic         diff_neg;
  logic         diff_zero;
  logic [19:0]  dt;

  logic [31:0]  dth;
  logic [31:0]  x;
  logic [31:0]  x2;
  logic [31:0]  t;
  logic [31:0]  smag;
  logic [31:0]  s0;
  logic [31:0]  c0;
  logic [31:0]  s1;
  logic [31:0]  c1;
  logic [63:0]  rq;
  logic [38:0]  den;
  logic [47:0]  dx;
  logic [47:0]  dy;
  logic [31:0]  speed_r;
  logic [31:0]  rate_r;

  logic [63:0]  ma;
  logic [63:0]  mhi;
  logic [31:0]  mlo;
  logic [71:0]  dq;
  logic [39:0]  drem;
  logic [39:0]  dden;
  logic [6:0]   cnt;
  logic         op_div;

  logic         accept;
  logic [18:0]  wb;
  logic signed [32:0] sum_in;
  logic signed [32:0] diff_in;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wb       = (wheel_base == 19'd0) ? 19'd1 : wheel_base;
  assign sum_in   = 33'(left_dist) + 33'(right_dist);
  assign diff_in  = 33'(right_dist) - 33'(left_dist);

  // quadrant reduction of the angle under evaluation
  logic [31:0] ang;
  logic [31:0] ang_sh;
  logic [1:0]  ang_q;
  logic [31:0] ang_r;
  logic        ang_rneg;
  logic [31:0] ang_ar;

  assign ang      = pass ? (acc_heading + dth) : acc_heading;
  assign ang_sh   = ang + 32'h2000_0000;
  assign ang_q    = ang_sh[31:30];
  assign ang_r    = ang - {ang_q, 30'b0};
  assign ang_rneg = ang_r[31];
  assign ang_ar   = ang_rneg ? (32'd0 - ang_r) : ang_r;

  logic [95:0] prod;
  logic [33:0] rnd30_w;
  logic [31:0] rnd30;
  logic [31:0] tq;
  logic [47:0] mag31;
  logic [47:0] mag43;

  assign prod    = {mhi, mlo};
  assign rnd30_w = prod[63:30] + {33'b0, prod[29]};
  assign rnd30   = rnd30_w[31:0];
  assign tq      = ONE_Q30 - dq[31:0];
  assign mag31   = prod[78:31] + {47'b0, prod[30]};
  assign mag43   = prod[90:43] + {47'b0, prod[42]};

  logic [32:0] ex;
  logic [32:0] ey;
  logic [32:0] ex_abs;
  logic [32:0] ey_abs;
  logic        rneg;

  assign ex     = {s1[31], s1} - {s0[31], s0};
  assign ey     = {c0[31], c0} - {c1[31], c1};
  assign ex_abs = ex[32] ? (33'd0 - ex) : ex;
  assign ey_abs = ey[32] ? (33'd0 - ey) : ey;
  assign rneg   = sum_neg ^ diff_neg;

  logic [31:0] sval;
  logic [31:0] sc_s;
  logic [31:0] sc_c;

  assign sval = ang_rneg ? (32'd0 - smag) : smag;

  always_comb begin
    unique case (ang_q)
      2'd0: begin
        sc_s = sval;
        sc_c = tq;
      end
      2'd1: begin
        sc_s = tq;
        sc_c = 32'd0 - sval;
      end
      2'd2: begin
        sc_s = 32'd0 - sval;
        sc_c = 32'd0 - tq;
      end
      default: begin
        sc_s = 32'd0 - tq;
        sc_c = sval;
      end
    endcase
  end

  // operands of the step being issued
  logic        iss_div;
  logic        iss_long;
  logic [63:0] iss_a;
  logic [31:0] iss_b;
  logic [71:0] iss_n;
  logic [39:0] iss_d;

  always_comb begin
    iss_div  = 1'b0;
    iss_long = 1'b0;
    iss_a    = '0;
    iss_b    = '0;
    iss_n    = '0;
    iss_d    = '0;
    unique case (pc)
      S_ANG_MUL: begin
        iss_a = 64'(udiff);
        iss_b = ANG_PER_RAD;
      end
      S_ANG_DIV: begin
        iss_div  = 1'b1;
        iss_long = 1'b1;
        iss_n    = prod[71:0] + 72'(wb[18:1]);
        iss_d    = 40'(wb);
      end
      S_X: begin
        iss_a = 64'(ang_ar);
        iss_b = PIHALF_Q30;
      end
      S_X2: begin
        iss_a = 64'(x);
        iss_b = x;
      end
      S_SD0: begin
        iss_div = 1'b1;
        iss_n   = 72'(x2);
        iss_d   = 40'd72;
      end
      S_SD1: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd42;
      end
      S_SD2: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd20;
      end
      S_SD3: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd6;
      end
      S_SM1, S_SM2, S_SM3, S_CM1, S_CM2, S_CM3, S_CM4: begin
        iss_a = 64'(x2);
        iss_b = t;
      end
      S_SX: begin
        iss_a = 64'(x);
        iss_b = t;
      end
      S_CD0: begin
        iss_div = 1'b1;
        iss_n   = 72'(x2);
        iss_d   = 40'd90;
      end
      S_CD1: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd56;
      end
      S_CD2: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd30;
      end
      S_CD3: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd12;
      end
      S_CD4: begin
        iss_div = 1'b1;
        iss_n   = 72'(rnd30);
        iss_d   = 40'd2;
      end
      S_STR_X: begin
        iss_a = 64'(usum);
        iss_b = mag32(c0);
      end
      S_STR_Y: begin
        iss_a = 64'(usum);
        iss_b = mag32(s0);
      end
      S_ARC_R: begin
        iss_a = 64'(usum);
        iss_b = 32'(wb);
      end
      S_ARC_RQ: begin
        iss_div  = 1'b1;
        iss_long = 1'b1;
        iss_n    = {prod[59:0], 12'b0};
        iss_d    = 40'(udiff);
      end
      S_ARC_X: begin
        iss_a = rq;
        iss_b = ex_abs[31:0];
      end
      S_ARC_Y: begin
        iss_a = rq;
        iss_b = ey_abs[31:0];
      end
      S_SPD_MUL: begin
        iss_a = 64'(usum);
        iss_b = US_PER_S;
      end
      S_SPD_DIV: begin
        iss_div  = 1'b1;
        iss_long = 1'b1;
        iss_n    = prod[71:0];
        iss_d    = 40'({dt, 1'b0});
      end
      S_RT_DEN: begin
        iss_a = 64'(wb);
        iss_b = 32'(dt);
      end
      S_RT_MUL: begin
        iss_a = 64'({udiff, 16'b0});
        iss_b = US_PER_S;
      end
      S_RT_DIV: begin
        iss_div  = 1'b1;
        iss_long = 1'b1;
        iss_n    = prod[71:0];
        iss_d    = 40'(den);
      end
    endcase
  end

  // one multiplier digit and one divider bit per cycle
  logic [67:0] mpart;
  logic [67:0] mstep;
  logic [40:0] dsh;
  logic [41:0] dsub;
  logic        dge;

  assign mpart = ma * mlo[3:0];
  assign mstep = {4'b0, mhi} + mpart;
  assign dsh   = {drem, dq[71]};
  assign dsub  = {1'b0, dsh} - {2'b0, dden};
  assign dge   = !dsub[41];

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      pc                <= S_ANG_MUL;
      pass              <= 1'b0;
      straight          <= 1'b0;
      op_div            <= 1'b0;
      cnt               <= '0;
      out_valid         <= 1'b0;
      wheel_base        <= WHEEL_BASE_RST;
      small_angle_limit <= SMALL_ANGLE_RST;
      acc_x             <= '0;
      acc_y             <= '0;
      acc_heading       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WHEEL_BASE:  wheel_base        <= cfg_data[18:0];
          REG_SMALL_ANGLE: small_angle_limit <= cfg_data;
        endcase
      end

      if (out_valid && !out_stall && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            usum      <= sum_in[32] ? (33'd0 - sum_in) : sum_in;
            udiff     <= diff_in[32] ? (33'd0 - diff_in) : diff_in;
            sum_neg   <= sum_in[32];
            diff_neg  <= diff_in[32];
            diff_zero <= (diff_in == 33'sd0);
            dt        <= (tick_time_us == 20'd0) ? 20'd1 : tick_time_us;
            pass      <= 1'b0;
            pc        <= S_ANG_MUL;
            state     <= ST_ISSUE;
          end
        end

        ST_ISSUE: begin
          op_div <= iss_div;
          if (iss_div) begin
            dq   <= iss_long ? iss_n : {iss_n[31:0], 40'b0};
            drem <= '0;
            dden <= iss_d;
            cnt  <= iss_long ? 7'd71 : 7'd31;
          end else begin
            ma  <= iss_a;
            mhi <= '0;
            mlo <= iss_b;
            cnt <= 7'd7;
          end
          state <= ST_WAIT;
        end

        ST_WAIT: begin
          if (op_div) begin
            drem <= dge ? dsub[39:0] : dsh[39:0];
            dq   <= {dq[70:0], dge};
          end else begin
            mhi <= mstep[67:4];
            mlo <= {mstep[3:0], mlo[31:4]};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd0) begin
            state <= ST_WB;
          end
        end

        ST_WB: begin
          state <= (pc == S_RT_DIV) ? ST_FINISH : ST_ISSUE;
          unique case (pc)
            S_ANG_MUL: pc <= S_ANG_DIV;
            S_ANG_DIV: begin
              dth      <= diff_neg ? (32'd0 - dq[31:0]) : dq[31:0];
              straight <= diff_zero ||
                          ((dq[71:31] == 41'd0) && (dq[30:0] < small_angle_limit));
              pc       <= S_X;
            end
            S_X: begin
              x  <= rnd30;
              pc <= S_X2;
            end
            S_X2: begin
              x2 <= rnd30;
              pc <= S_SD0;
            end
            S_SD0: begin
              t  <= tq;
              pc <= S_SM1;
            end
            S_SM1: pc <= S_SD1;
            S_SD1: begin
              t  <= tq;
              pc <= S_SM2;
            end
            S_SM2: pc <= S_SD2;
            S_SD2: begin
              t  <= tq;
              pc <= S_SM3;
            end
            S_SM3: pc <= S_SD3;
            S_SD3: begin
              t  <= tq;
              pc <= S_SX;
            end
            S_SX: begin
              smag <= rnd30;
              pc   <= S_CD0;
            end
            S_CD0: begin
              t  <= tq;
              pc <= S_CM1;
            end
            S_CM1: pc <= S_CD1;
            S_CD1: begin
              t  <= tq;
              pc <= S_CM2;
            end
            S_CM2: pc <= S_CD2;
            S_CD2: begin
              t  <= tq;
              pc <= S_CM3;
            end
            S_CM3: pc <= S_CD3;
            S_CD3: begin
              t  <= tq;
              pc <= S_CM4;
            end
            S_CM4: pc <= S_CD4;
            S_CD4: begin
              if (pass) begin
                s1 <= sc_s;
                c1 <= sc_c;
                pc <= S_ARC_R;
              end else begin
                s0 <= sc_s;
                c0 <= sc_c;
                if (straight) begin
                  pc <= S_STR_X;
                end else begin
                  pass <= 1'b1;
                  pc   <= S_X;
                end
              end
            end
            S_STR_X: begin
              dx <= (sum_neg ^ c0[31]) ? (48'd0 - mag31) : mag31;
              pc <= S_STR_Y;
            end
            S_STR_Y: begin
              dy <= (sum_neg ^ s0[31]) ? (48'd0 - mag31) : mag31;
              pc <= S_SPD_MUL;
            end
            S_ARC_R: pc <= S_ARC_RQ;
            S_ARC_RQ: begin
              rq <= dq[63:0];
              pc <= S_ARC_X;
            end
            S_ARC_X: begin
              dx <= (rneg ^ ex[32]) ? (48'd0 - mag43) : mag43;
              pc <= S_ARC_Y;
            end
            S_ARC_Y: begin
              dy <= (rneg ^ ey[32]) ? (48'd0 - mag43) : mag43;
              pc <= S_SPD_MUL;
            end
            S_SPD_MUL: pc <= S_SPD_DIV;
            S_SPD_DIV: begin
              speed_r <= sat32(dq, sum_neg);
              pc      <= S_RT_DEN;
            end
            S_RT_DEN: begin
              den <= prod[38:0];
              pc  <= S_RT_MUL;
            end
            S_RT_MUL: pc <= S_RT_DIV;
            S_RT_DIV: begin
              rate_r <= sat32(dq, diff_neg);
            end
          endcase
        end

        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            acc_x       <= acc_x + dx;
            acc_y       <= acc_y + dy;
            acc_heading <= acc_heading + dth;
            pos_x       <= acc_x + dx;
            pos_y       <= acc_y + dy;
            heading     <= acc_heading + dth;
            speed       <= speed_r;
            turn_rate   <= rate_r;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_stall_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken while a tick is in work");

  a_out_matches_pose: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pos_x == acc_x) && (pos_y == acc_y) && (heading == acc_heading))
    else $error("output register out of step with pose");

  a_arc_pass_only_on_arc: assert property (@(posedge clk) disable iff (rst)
    pass |-> !straight)
    else $error("second angle pass on a straight tick");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && !op_div) |-> (cnt <= 7'd7))
    else $error("multiplier step count out of range");
`endif

endmodule

`default_nettype wire
